@@ rtl/core/sdpl_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the sorted descending priority list.
// No dependencies.
package sdpl_pkg;

  localparam int DEFAULT_CAPACITY = 32;
  localparam int COST_W           = 32;
  localparam int TAG_W            = 16;
  localparam int FILL_W           = 6;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [COST_W-1:0] cost;
    logic [TAG_W-1:0]         period;
    logic [TAG_W-1:0]         plant;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t item;
  } cell_ctl_t;

endpackage

@@ rtl/core/sdpl_if.sv @@
`timescale 1ns / 1ps
// Request and result channels of the sorted descending priority list.
// Depends on nothing.
interface sdpl_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [31:0] cost;
  logic [15:0]        period;
  logic [15:0]        plant;

  modport source (output valid, output opcode, output cost, output period, output plant,
                  input ready);
  modport sink   (input valid, input opcode, input cost, input period, input plant,
                  output ready);
endinterface

interface sdpl_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] out_cost;
  logic [15:0]        out_period;
  logic [15:0]        out_plant;
  logic [5:0]         fill_count;

  modport source (output valid, output status, output out_cost, output out_period,
                  output out_plant, output fill_count, input ready);
  modport sink   (input valid, input status, input out_cost, input out_period,
                  input out_plant, input fill_count, output ready);
endinterface

@@ rtl/core/sdpl_cell.sv @@
`timescale 1ns / 1ps
// One slot of the sorted row: holds an entry, compares against the broadcast
// key, and shifts from its neighbors. Depends on sdpl_pkg.
module sdpl_cell
  import sdpl_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occupied,
  input  logic      left_keep,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  output logic      keep,
  output entry_t    entry
);

  // stays in place on insert: holds a strictly greater cost
  assign keep = occupied && ($signed(entry.cost) > $signed(ctl.item.cost));

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (!keep) begin
        entry <= left_keep ? ctl.item : left_entry;
      end
    end else if (ctl.pop) begin
      entry <= right_entry;
    end
  end

endmodule

@@ rtl/core/sorted_descending_priority_list_core.sv @@
`timescale 1ns / 1ps
// Sorted descending priority list: a row of CAPACITY cells kept in
// descending cost order; one request per cycle unless an untaken result
// stalls it. Depends on sdpl_pkg, sdpl_if and sdpl_cell.
//
// Requests insert an entry (cost, period, plant) in order or pop the head.
// Every cell compares the new cost against its own in the same cycle and
// either holds, takes the new entry or takes its left neighbor, so an
// insert or pop updates all cells at once regardless of fill level; equal
// costs place the newest first. Throughput is one request per clock while
// the result is free or being taken; acceptance loads the result
// register, which is held until taken. Inserts into a full row report
// full, pops of an empty row report empty; neither changes the contents.
module sorted_descending_priority_list_core
  import sdpl_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  sdpl_req_if.sink   req,
  sdpl_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic                rsp_valid;
  status_t             rsp_status;
  entry_t              rsp_entry;
  logic [FILL_W-1:0]   rsp_fill;

  cell_ctl_t           ctl;
  entry_t              cells [CAPACITY];
  logic [CAPACITY-1:0] keeps;

  logic    accept;
  logic    is_pop;
  logic    full;
  logic    empty;
  status_t status_next;
  entry_t  pop_entry;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign is_pop    = (opcode_t'(req.opcode) == OP_POP);
  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);

  always_comb begin
    ctl.ins         = accept && !is_pop && !full;
    ctl.pop         = accept && is_pop && !empty;
    ctl.item.cost   = req.cost;
    ctl.item.period = req.period;
    ctl.item.plant  = req.plant;

    count_next  = count;
    status_next = ST_OK;
    pop_entry   = '0;
    if (ctl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.pop) begin
      count_next = count - CNT_W'(1);
      pop_entry  = cells[0];
    end else if (is_pop) begin
      status_next = ST_EMPTY;
    end else begin
      status_next = ST_FULL;
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic   left_keep;
      entry_t left_entry;
      entry_t right_entry;

      if (i == 0) begin : g_head
        assign left_keep  = 1'b1;
        assign left_entry = '0;
      end else begin : g_body
        assign left_keep  = keeps[i-1];
        assign left_entry = cells[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign right_entry = '0;
      end else begin : g_inner
        assign right_entry = cells[i+1];
      end

      sdpl_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .occupied    (count > CNT_W'(i)),
        .left_keep   (left_keep),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .keep        (keeps[i]),
        .entry       (cells[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status <= status_next;
      rsp_entry  <= pop_entry;
      rsp_fill   <= FILL_W'(count_next);
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.out_cost   = rsp_entry.cost;
  assign rsp.out_period = rsp_entry.period;
  assign rsp.out_plant  = rsp_entry.plant;
  assign rsp.fill_count = rsp_fill;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the count");

  a_pop_head: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |=> rsp.valid && rsp.out_cost == $past(cells[0].cost)
                && rsp.status == ST_OK)
    else $error("pop result does not match head entry");

  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    count >= CNT_W'(2) |-> $signed(cells[0].cost) >= $signed(cells[1].cost))
    else $error("head pair out of order");

  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    accept && !ctl.ins && !ctl.pop |=> count == $past(count) && rsp.status != ST_OK)
    else $error("rejected request changed state or reported ok");

endmodule

@@ test/sorted_descending_priority_list_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench for sorted_descending_priority_list_core: random-gap request driver, random-stall
// result sink, a queue-based sorted-list predictor. Depends on the core, sdpl_pkg, sdpl_if.
module sorted_descending_priority_list_core_tb;
  import sdpl_pkg::*;

  localparam int LIST_DEPTH  = DEFAULT_CAPACITY;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    status_t                  status;
    logic signed [COST_W-1:0] cost;
    logic [TAG_W-1:0]         period;
    logic [TAG_W-1:0]         plant;
    logic [FILL_W-1:0]        fill;
  } list_result_t;

  logic clk;
  logic rst;

  sdpl_req_if req();
  sdpl_rsp_if rsp();

  sorted_descending_priority_list_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  entry_t       sorted_entries[$];
  list_result_t pending_results[$];
  list_result_t exp_res;

  int error_count;
  int cycle_count;
  int n_insert;
  int n_pop;
  int n_results;
  int n_full;
  int n_empty;
  int sink_hold;
  int sink_pick;
  bit steady_flow;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // predicted list after one request, and the result it gives
  function automatic list_result_t apply_list_op(opcode_t op, logic signed [COST_W-1:0] c,
                                                 logic [TAG_W-1:0] per, logic [TAG_W-1:0] pl);
    list_result_t res;
    entry_t       e;
    int           pos;
    res.status = ST_OK;
    res.cost   = '0;
    res.period = '0;
    res.plant  = '0;
    if (op == OP_INSERT) begin
      if (sorted_entries.size() >= LIST_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < sorted_entries.size() && sorted_entries[pos].cost > c) pos++;
        e.cost   = c;
        e.period = per;
        e.plant  = pl;
        sorted_entries.insert(pos, e);
      end
    end else begin
      if (sorted_entries.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        e          = sorted_entries.pop_front();
        res.cost   = e.cost;
        res.period = e.period;
        res.plant  = e.plant;
      end
    end
    res.fill = FILL_W'(sorted_entries.size());
    return res;
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result sink: mostly ready, short stalls, a few long ones
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      sink_hold = 0;
    end else if (steady_flow) begin
      rsp.ready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold--;
      rsp.ready <= 1'b0;
    end else begin
      sink_pick = $urandom_range(0, 99);
      if (sink_pick < 70) begin
        rsp.ready <= 1'b1;
      end else if (sink_pick < 97) begin
        rsp.ready <= 1'b0;
        sink_hold = $urandom_range(0, 3);
      end else begin
        rsp.ready <= 1'b0;
        sink_hold = $urandom_range(10, 40);
      end
    end
  end

  // check results first, then predict accepted requests
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d", rsp.status);
          error_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (exp_res.status == ST_FULL) n_full++;
          if (exp_res.status == ST_EMPTY) n_empty++;
          if (rsp.status !== exp_res.status) begin
            $error("status expected %0d got %0d", exp_res.status, rsp.status);
            error_count++;
          end
          if (rsp.out_cost !== exp_res.cost) begin
            $error("out_cost expected %0d got %0d", exp_res.cost, rsp.out_cost);
            error_count++;
          end
          if (rsp.out_period !== exp_res.period) begin
            $error("out_period expected %0d got %0d", exp_res.period, rsp.out_period);
            error_count++;
          end
          if (rsp.out_plant !== exp_res.plant) begin
            $error("out_plant expected %0d got %0d", exp_res.plant, rsp.out_plant);
            error_count++;
          end
          if (rsp.fill_count !== exp_res.fill) begin
            $error("fill_count expected %0d got %0d", exp_res.fill, rsp.fill_count);
            error_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        if (opcode_t'(req.opcode) == OP_INSERT) n_insert++;
        else n_pop++;
        pending_results.push_back(apply_list_op(opcode_t'(req.opcode), req.cost,
                                                req.period, req.plant));
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // mix of extremes, a few tie-prone values and full-range keys
  function automatic logic signed [COST_W-1:0] pick_cost();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return 32'sh0000_0000;
        3:       return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    if (r < 4) return ($urandom_range(0, 4) - 2) <<< 16;
    return $urandom;
  endfunction

  task automatic send_request(opcode_t op, logic signed [COST_W-1:0] c,
                              logic [TAG_W-1:0] per, logic [TAG_W-1:0] pl);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid  <= 1'b1;
    req.opcode <= op;
    req.cost   <= c;
    req.period <= per;
    req.plant  <= pl;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic send_insert(logic signed [COST_W-1:0] c);
    send_request(OP_INSERT, c, TAG_W'($urandom), TAG_W'($urandom));
  endtask

  // pop with junk in the ignored fields
  task automatic send_pop();
    send_request(OP_POP, $urandom, TAG_W'($urandom), TAG_W'($urandom));
  endtask

  task automatic test_directed();
    send_request(OP_POP, 32'sh7fff_ffff, 16'hffff, 16'hffff);
    send_request(OP_INSERT, 32'sh0000_0000, 16'h0000, 16'h0000);
    send_request(OP_INSERT, 32'sh7fff_ffff, 16'hffff, 16'hffff);
    send_request(OP_INSERT, 32'sh8000_0000, 16'h1234, 16'habcd);
    send_request(OP_INSERT, 32'sh0000_0000, 16'h0001, 16'h0001);
    send_request(OP_INSERT, -32'sd1, 16'h0002, 16'h5555);
    send_request(OP_INSERT, 32'sd1, 16'h0003, 16'haaaa);
    send_request(OP_INSERT, 32'sh7fff_ffff, 16'h0004, 16'h8000);
    send_request(OP_INSERT, 32'sh8000_0000, 16'h0005, 16'h7fff);
    repeat (8) send_request(OP_POP, 32'sh5a5a_a5a5, 16'hffff, 16'h0000);
    send_request(OP_POP, 32'sh8000_0000, 16'h0000, 16'hffff);
  endtask

  task automatic test_fill_and_drain();
    repeat (LIST_DEPTH) send_insert(pick_cost());
    repeat (3) send_insert(pick_cost());
    repeat (LIST_DEPTH) send_pop();
    repeat (3) send_pop();
  endtask

  // insert bias changes in blocks so the fill level wanders across its range
  task automatic test_random_mixed(int count);
    int bias;
    bias = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       bias = 25;
          1:       bias = 50;
          default: bias = 80;
        endcase
      end
      if ($urandom_range(0, 99) < bias) send_insert(pick_cost());
      else send_pop();
    end
  endtask

  task automatic test_equal_costs(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 60) send_insert(($urandom_range(0, 2) - 1) <<< 16);
      else send_pop();
    end
  endtask

  task automatic test_back_to_back(int count);
    steady_flow = 1'b1;
    test_fill_and_drain();
    test_random_mixed(count);
    steady_flow = 1'b0;
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    n_insert    = 0;
    n_pop       = 0;
    n_results   = 0;
    n_full      = 0;
    n_empty     = 0;
    steady_flow = 1'b0;
    rst        <= 1'b1;
    req.valid  <= 1'b0;
    req.opcode <= OP_INSERT;
    req.cost   <= '0;
    req.period <= '0;
    req.plant  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_fill_and_drain();
    test_random_mixed(600);
    test_equal_costs(150);
    test_back_to_back(200);
    req.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("tb: %0d requests (%0d inserts, %0d pops), %0d results checked",
             n_insert + n_pop, n_insert, n_pop, n_results);
    $display("tb: %0d rejected inserts on a full list, %0d pops on an empty list",
             n_full, n_empty);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
